// ===== hdl/lrkv_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
// Used by lrkv_lookup and lru_key_value_cache_unit; depends on nothing else.
`default_nettype none

package lrkv_pkg;

    // Number of cache entries (supported range 1 to 64).
    localparam int ENTRIES = 16;

    // Slot index and recency rank width, count width (holds ENTRIES itself).
    localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W = SLOT_W;
    localparam int CNT_W  = $clog2(ENTRIES + 1);

    // Capacity register width is fixed by the register map.
    localparam int CAP_W = 5;
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;

    // Operation codes.
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // Value returned by a get that misses.
    localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;

    typedef logic [KEY_W-1:0]        key_t;
    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [RANK_W-1:0]       rank_t;

    typedef struct packed {
        logic op;
        key_t key;
        val_t write_value;
    } in_item_t;

    typedef struct packed {
        logic hit;
        val_t read_value;
        logic evicted;
        key_t evicted_key;
    } out_item_t;

    // Result of the parallel search over all entries.
    typedef struct packed {
        logic [ENTRIES-1:0] hit_vec;
        logic               hit_any;
        rank_t              hit_rank;
        val_t               hit_value;
        logic [ENTRIES-1:0] victim_vec;
        logic               victim_any;
        key_t               victim_key;
        logic [ENTRIES-1:0] free_vec;
        logic               free_any;
    } lookup_t;

endpackage

`default_nettype wire

// ===== hdl/lru_key_value_cache_unit.sv =====
// LRU key-value cache top level; uses lrkv_pkg and lrkv_lookup.
// Path: a beat accepted into the input register moves on to the result register, and
// it is taken at the output from there.
// Throughput: one access per cycle; the search and rank update are combinational
// between the input register and the result register, and stall only on out_ready.
// Reset (rst_n, async, active low) empties the cache and sets capacity to 16;
// no clearing pass is needed, so accesses are taken right after reset.
`default_nettype none

module lru_key_value_cache_unit
    import lrkv_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,

    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire in_item_t         in_data,

    output logic                  out_valid,
    input  wire logic             out_ready,
    output out_item_t             out_data,

    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CAP_W-1:0] cfg_data
);

    // Input stage register.
    logic               s0_valid_reg;
    in_item_t           s0_item_reg;

    // Result register.
    logic               out_valid_reg;
    out_item_t          out_item_reg;
    out_item_t          out_item_next;

    // Capacity register.
    logic [CAP_W-1:0]   cap_reg;

    // Cache state. Keys and values carry no reset; they are only read when valid.
    key_t  [ENTRIES-1:0] key_reg;
    val_t  [ENTRIES-1:0] value_reg;
    logic  [ENTRIES-1:0] valid_reg;
    logic  [ENTRIES-1:0] valid_next;
    rank_t [ENTRIES-1:0] rank_reg;
    rank_t [ENTRIES-1:0] rank_next;
    logic  [CNT_W-1:0]   fill_reg;
    logic  [CNT_W-1:0]   fill_next;

    logic                s0_advance;
    logic                process;
    logic                is_put;
    logic [CMP_W-1:0]    eff_cap;
    logic                at_capacity;
    logic                do_evict;
    logic                do_insert;
    logic [ENTRIES-1:0]  ins_vec;
    logic [ENTRIES-1:0]  key_we;
    logic [ENTRIES-1:0]  val_we;
    lookup_t             lk;

    // The input stage moves on whenever the result register is empty or being drained,
    // so a new beat is taken every cycle while the consumer keeps up.
    assign s0_advance = !out_valid_reg || out_ready;
    assign process    = s0_valid_reg && s0_advance;
    assign in_ready   = !s0_valid_reg || s0_advance;
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_item_reg;
    assign is_put     = (s0_item_reg.op == OP_PUT);

    lrkv_lookup u_lookup
    (
        .key    (s0_item_reg.key),
        .keys   (key_reg),
        .values (value_reg),
        .valids (valid_reg),
        .ranks  (rank_reg),
        .fill   (fill_reg),
        .result (lk)
    );

    // Effective capacity: zero behaves as one, anything above the entry count saturates.
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (CMP_W'(cap_reg) > CMP_W'(ENTRIES))
        begin
            eff_cap = CMP_W'(ENTRIES);
        end
        else
        begin
            eff_cap = CMP_W'(cap_reg);
        end
    end

    // A put that misses evicts the least recent entry once the cache is at capacity.
    // If capacity was lowered below the fill count, no entry is dropped: each later insert
    // evicts one entry for the new one, so the fill count stays above capacity.
    assign at_capacity = (CMP_W'(fill_reg) >= eff_cap) && (fill_reg != '0);
    assign do_evict    = is_put && !lk.hit_any && at_capacity && lk.victim_any;
    assign ins_vec     = do_evict ? lk.victim_vec : lk.free_vec;
    assign do_insert   = is_put && !lk.hit_any && (do_evict || lk.free_any);

    assign key_we = (process && do_insert) ? ins_vec : '0;
    assign val_we = key_we | ((process && is_put && lk.hit_any) ? lk.hit_vec : '0);

    // Recency ranks: 0 is most recent. A hit moves its entry to the front and ages the
    // entries that were ahead of it; an insert ages every valid entry and puts the new
    // one at the front, reusing the victim slot when one was evicted.
    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        fill_next  = fill_reg;
        if (process)
        begin
            if (lk.hit_any)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (lk.hit_vec[i])
                    begin
                        rank_next[i] = '0;
                    end
                    else if (valid_reg[i] && (rank_reg[i] < lk.hit_rank))
                    begin
                        rank_next[i] = rank_reg[i] + 1'b1;
                    end
                end
            end
            else if (do_insert)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (ins_vec[i])
                    begin
                        valid_next[i] = 1'b1;
                        rank_next[i]  = '0;
                    end
                    else if (valid_reg[i])
                    begin
                        rank_next[i] = rank_reg[i] + 1'b1;
                    end
                end
                if (!do_evict)
                begin
                    fill_next = fill_reg + 1'b1;
                end
            end
        end
    end

    // Result beat for the access in the input stage.
    always_comb
    begin
        out_item_next.hit         = lk.hit_any;
        out_item_next.evicted     = do_evict;
        out_item_next.evicted_key = do_evict ? lk.victim_key : '0;
        if (is_put)
        begin
            out_item_next.read_value = '0;
        end
        else if (lk.hit_any)
        begin
            out_item_next.read_value = lk.hit_value;
        end
        else
        begin
            out_item_next.read_value = MISS_VALUE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cap_reg       <= CAP_RESET;
            valid_reg     <= '0;
            rank_reg      <= '0;
            fill_reg      <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s0_valid_reg <= in_valid;
            end
            if (s0_advance)
            begin
                out_valid_reg <= s0_valid_reg;
            end
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            fill_reg  <= fill_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s0_item_reg <= in_data;
        end
        if (process)
        begin
            out_item_reg <= out_item_next;
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (key_we[i])
            begin
                key_reg[i] <= s0_item_reg.key;
            end
            if (val_we[i])
            begin
                value_reg[i] <= s0_item_reg.write_value;
            end
        end
    end

    // The fill count always matches the number of valid entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(fill_reg))
        else $error("fill count does not match valid entries");

    // Keys are unique among valid entries, so at most one entry hits.
    assert property (@(posedge clk) disable iff (!rst_n)
        s0_valid_reg |-> $onehot0(lk.hit_vec))
        else $error("more than one entry hit");

    // Ranks of valid entries are distinct, so at most one least-recent entry exists.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(lk.victim_vec))
        else $error("more than one least recent entry");

    // An eviction replaces one entry with another, leaving the fill count unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (process && do_evict) |=> $stable(fill_reg))
        else $error("fill count changed on eviction");

    // A full cache never takes an insert without evicting.
    assert property (@(posedge clk) disable iff (!rst_n)
        (process && do_insert && (fill_reg == CNT_W'(ENTRIES))) |-> do_evict)
        else $error("insert into a full cache without eviction");

endmodule

`default_nettype wire

// ===== hdl/lrkv_lookup.sv =====
// Parallel tag compare, victim select and free-slot select over all entries.
// Depends on lrkv_pkg.
`default_nettype none

module lrkv_lookup
    import lrkv_pkg::*;
(
    input  wire key_t                      key,
    input  wire key_t  [ENTRIES-1:0]       keys,
    input  wire val_t  [ENTRIES-1:0]       values,
    input  wire logic  [ENTRIES-1:0]       valids,
    input  wire rank_t [ENTRIES-1:0]       ranks,
    input  wire logic  [CNT_W-1:0]         fill,
    output lookup_t                        result
);

    logic [CNT_W-1:0] oldest;

    assign oldest = fill - 1'b1;

    always_comb
    begin
        result = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            result.hit_vec[i]    = valids[i] && (keys[i] == key);
            result.victim_vec[i] = valids[i] && (CNT_W'(ranks[i]) == oldest);
            if (result.hit_vec[i])
            begin
                result.hit_rank  = result.hit_rank | ranks[i];
                result.hit_value = result.hit_value | values[i];
            end
            if (result.victim_vec[i])
            begin
                result.victim_key = result.victim_key | keys[i];
            end
        end
        // Lowest invalid slot: isolate the lowest set bit of the inverted valids.
        result.free_vec   = ~valids & (valids + 1'b1);
        result.hit_any    = |result.hit_vec;
        result.victim_any = |result.victim_vec;
        result.free_any   = |result.free_vec;
    end

endmodule

`default_nettype wire
